// ===== rtl/saps_pkg.sv =====
// saps_pkg: shared types and codes for the sleep aware process scheduler
// no dependencies; used by every rtl file of the block

package saps_pkg;

   localparam logic [1:0] ST_DEAD     = 2'd0;
   localparam logic [1:0] ST_RUNNABLE = 2'd1;
   localparam logic [1:0] ST_RUNNING  = 2'd2;
   localparam logic [1:0] ST_BLOCKED  = 2'd3;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_FORK  = 2'd1;
   localparam logic [1:0] REQ_SLEEP = 2'd2;
   localparam logic [1:0] REQ_EXIT  = 2'd3;

   localparam logic [7:0] TIME_SLICE_RESET = 8'd10;
   localparam logic [7:0] SLICE_MAX        = 8'd255;

   typedef struct packed {
      logic [1:0]  state;
      logic [15:0] sleep_left;
      logic [7:0]  slice_used;
   } slot_word_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        is_cur;
      logic        is_zero;
      logic [15:0] ticks;
   } slot_ctrl_type;

endpackage

// ===== rtl/sleep_aware_process_scheduler_core.sv =====
// sleep_aware_process_scheduler_core: top level, sequencer and handshake
// tick, sleep and exit: read and write back every slot, then finish the current slot and, on a switch, the picked slot
// fork: read slots upward from 0 until the lowest dead slot is claimed, or through the last slot
// one transaction at a time; req_ready returns in the same cycle the response is raised
// synchronous reset returns control to its reset values; table valid bits make it read as reset values at once
// depends on saps_pkg, saps_slot_mem, saps_slot_unit

module sleep_aware_process_scheduler_core #(
   parameter int NUM_PROCS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_sleep_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_running_proc,
   output logic        rsp_switched,
   output logic        rsp_fork_ok,
   output logic [2:0]  rsp_fork_child
);

   localparam int IDX_W = $clog2(NUM_PROCS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCS - 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_RD       = 3'd1;
   localparam logic [2:0] S_WR       = 3'd2;
   localparam logic [2:0] S_FIN_CUR  = 3'd3;
   localparam logic [2:0] S_FIN_PICK = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [1:0]              op_ff, op_in;
   logic [15:0]             ticks_ff, ticks_in;
   logic [IDX_W-1:0]        cur_ff, cur_in;
   logic [IDX_W-1:0]        before_ff, before_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        pick_ff, pick_in;
   saps_pkg::slot_word_type pick_word_ff, pick_word_in;
   saps_pkg::slot_word_type cur_word_ff, cur_word_in;
   logic                    fork_ok_ff, fork_ok_in;
   logic [IDX_W-1:0]        child_ff, child_in;
   logic [7:0]              time_slice_ff, time_slice_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_running_ff, rsp_running_in;
   logic                    rsp_switched_ff, rsp_switched_in;
   logic                    rsp_fork_ok_ff, rsp_fork_ok_in;
   logic [2:0]              rsp_child_ff, rsp_child_in;

   logic                    mem_rd_en;
   saps_pkg::slot_word_type mem_rd_word;
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   saps_pkg::slot_word_type mem_wr_word;
   saps_pkg::slot_ctrl_type unit_ctrl;
   saps_pkg::slot_word_type unit_word;
   logic                    need_switch;
   logic [IDX_W+2:0]        cur_ext;
   logic [IDX_W+2:0]        child_ext;

   saps_slot_mem #(
      .NUM_PROCS (NUM_PROCS),
      .IDX_W     (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_word (mem_rd_word),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_word (mem_wr_word)
   );

   always_comb begin
      unit_ctrl.op      = op_ff;
      unit_ctrl.is_cur  = (idx_ff == cur_ff);
      unit_ctrl.is_zero = (idx_ff == '0);
      unit_ctrl.ticks   = ticks_ff;
   end

   saps_slot_unit u_unit (
      .ctrl     (unit_ctrl),
      .word_in  (mem_rd_word),
      .word_out (unit_word)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign cur_ext   = {3'b000, cur_ff};
   assign child_ext = {3'b000, child_ff};

   assign need_switch = (cur_word_ff.slice_used >= time_slice_ff)
                     || (cur_word_ff.state == saps_pkg::ST_DEAD)
                     || (cur_word_ff.state == saps_pkg::ST_BLOCKED)
                     || (cur_ff == '0);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      op_in           = op_ff;
      ticks_in        = ticks_ff;
      cur_in          = cur_ff;
      before_in       = before_ff;
      found_in        = found_ff;
      pick_in         = pick_ff;
      pick_word_in    = pick_word_ff;
      cur_word_in     = cur_word_ff;
      fork_ok_in      = fork_ok_ff;
      child_in        = child_ff;
      time_slice_in   = csr_wen ? csr_wdata : time_slice_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_running_in  = rsp_running_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_fork_ok_in  = rsp_fork_ok_ff;
      rsp_child_in    = rsp_child_ff;
      mem_rd_en       = 1'b0;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = idx_ff;
      mem_wr_word     = unit_word;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_type;
               ticks_in   = req_sleep_ticks;
               before_in  = cur_ff;
               idx_in     = '0;
               found_in   = 1'b0;
               pick_in    = '0;
               fork_ok_in = 1'b0;
               child_in   = '0;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_WR;
         end
         S_WR: begin
            if (op_ff == saps_pkg::REQ_FORK) begin
               if (mem_rd_word.state == saps_pkg::ST_DEAD) begin
                  mem_wr_en              = 1'b1;
                  mem_wr_word.state      = saps_pkg::ST_RUNNABLE;
                  mem_wr_word.sleep_left = 16'd0;
                  mem_wr_word.slice_used = 8'd0;
                  fork_ok_in             = 1'b1;
                  child_in               = idx_ff;
                  state_in               = S_DONE;
               end else if (idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end else begin
               mem_wr_en = 1'b1;
               if (idx_ff == cur_ff) begin
                  cur_word_in = unit_word;
               end
               if (idx_ff != '0 && idx_ff != cur_ff
                   && unit_word.state == saps_pkg::ST_RUNNABLE) begin
                  found_in     = 1'b1;
                  pick_in      = idx_ff;
                  pick_word_in = unit_word;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FIN_CUR;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_FIN_CUR: begin
            if (need_switch) begin
               if (cur_word_ff.state == saps_pkg::ST_RUNNING) begin
                  mem_wr_en              = 1'b1;
                  mem_wr_addr            = cur_ff;
                  mem_wr_word.state      = saps_pkg::ST_RUNNABLE;
                  mem_wr_word.sleep_left = cur_word_ff.sleep_left;
                  mem_wr_word.slice_used = 8'd0;
               end
               state_in = S_FIN_PICK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIN_PICK: begin
            if (found_ff) begin
               mem_wr_en              = 1'b1;
               mem_wr_addr            = pick_ff;
               mem_wr_word.state      = saps_pkg::ST_RUNNING;
               mem_wr_word.sleep_left = pick_word_ff.sleep_left;
               mem_wr_word.slice_used = pick_word_ff.slice_used;
               cur_in                 = pick_ff;
            end else begin
               cur_in = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_running_in  = cur_ext[2:0];
               rsp_switched_in = (cur_ff != before_ff);
               rsp_fork_ok_in  = fork_ok_ff;
               rsp_child_in    = child_ext[2:0];
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         time_slice_ff <= saps_pkg::TIME_SLICE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         time_slice_ff <= time_slice_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      op_ff           <= op_in;
      ticks_ff        <= ticks_in;
      before_ff       <= before_in;
      found_ff        <= found_in;
      pick_ff         <= pick_in;
      pick_word_ff    <= pick_word_in;
      cur_word_ff     <= cur_word_in;
      fork_ok_ff      <= fork_ok_in;
      child_ff        <= child_in;
      rsp_running_ff  <= rsp_running_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_fork_ok_ff  <= rsp_fork_ok_in;
      rsp_child_ff    <= rsp_child_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_proc = rsp_running_ff;
   assign rsp_switched     = rsp_switched_ff;
   assign rsp_fork_ok      = rsp_fork_ok_ff;
   assign rsp_fork_child   = rsp_child_ff;

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_RD))
      else $error("accepted transaction did not start the slot walk");

   a_cur_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_ff} < (IDX_W + 1)'(NUM_PROCS)))
      else $error("current slot out of range");

   a_pick_not_cur: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN_PICK && found_ff) |-> (pick_ff != cur_ff))
      else $error("picked slot equals current slot");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside completion");

   a_fork_no_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fork_ok_ff) |-> !rsp_switched_ff)
      else $error("fork changed the current slot");

endmodule

// ===== rtl/saps_slot_mem.sv =====
// saps_slot_mem: per-slot table (state, sleep counter, slice count)
// one read and one write port, registered read; valid bits give reset values
// depends on saps_pkg

module saps_slot_mem #(
   parameter int NUM_PROCS = 8,
   parameter int IDX_W     = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output saps_pkg::slot_word_type rd_word,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  saps_pkg::slot_word_type wr_word
);

   saps_pkg::slot_word_type mem_ff [NUM_PROCS];
   logic [NUM_PROCS-1:0]    vld_ff;
   saps_pkg::slot_word_type rd_q_ff;
   logic                    rd_vld_ff;
   logic                    rd_zero_ff;
   saps_pkg::slot_word_type rst_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_q_ff    <= mem_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
         rd_zero_ff <= (rd_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // slot 0 starts running, the rest dead
   always_comb begin
      rst_word.state      = rd_zero_ff ? saps_pkg::ST_RUNNING : saps_pkg::ST_DEAD;
      rst_word.sleep_left = 16'd0;
      rst_word.slice_used = 8'd0;
      rd_word             = rd_vld_ff ? rd_q_ff : rst_word;
   end

endmodule

// ===== rtl/saps_slot_unit.sv =====
// saps_slot_unit: shared update of one slot entry per step
// applies sleep/exit to the current slot, sleep countdown, slice charge
// depends on saps_pkg

module saps_slot_unit (
   input  saps_pkg::slot_ctrl_type ctrl,
   input  saps_pkg::slot_word_type word_in,
   output saps_pkg::slot_word_type word_out
);

   saps_pkg::slot_word_type w;

   always_comb begin
      w = word_in;
      if (ctrl.is_cur && ctrl.op == saps_pkg::REQ_SLEEP) begin
         w.state      = saps_pkg::ST_BLOCKED;
         w.sleep_left = ctrl.ticks;
      end else if (ctrl.is_cur && ctrl.op == saps_pkg::REQ_EXIT) begin
         w.state = saps_pkg::ST_DEAD;
      end
      if (!ctrl.is_zero && w.state == saps_pkg::ST_BLOCKED) begin
         w.sleep_left = w.sleep_left - 16'd1;
         if (w.sleep_left == 16'd0) begin
            w.state = saps_pkg::ST_RUNNABLE;
         end
      end
      if (ctrl.is_cur && w.slice_used != saps_pkg::SLICE_MAX) begin
         w.slice_used = w.slice_used + 8'd1;
      end
      word_out = w;
   end

endmodule
